FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the display frame blinker.
// Depends on nothing; each file that asserts includes it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the given reset is high.
`define FDFB_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("fdfb assertion failed");

// Next-cycle implication, disabled while the given reset is high.
`define FDFB_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("fdfb assertion failed");

`endif

FILE: sv/fdfb_pkg.sv
// Package for the four-digit display frame blinker: constants, request codes,
// the internal command type passed from the front end to the back end.
// Depends on nothing.
package fdfb_pkg;

  localparam int DIGIT_SLOTS      = 4;
  localparam int ICON_SLOTS_DEF   = 8;
  localparam int PERIOD_WIDTH_DEF = 16;
  localparam int COLON_BIT        = 4;
  localparam int ICON_SHIFT       = 5;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

  localparam logic [3:0]  BLANK_CODE = 4'd15;
  localparam logic [15:0] NUM_MAX    = 16'd9999;

  // Request codes as seen on the input channel.
  localparam logic [3:0] REQ_CLEAR       = 4'd0;
  localparam logic [3:0] REQ_TIME        = 4'd1;
  localparam logic [3:0] REQ_NUMBER      = 4'd2;
  localparam logic [3:0] REQ_COLON       = 4'd3;
  localparam logic [3:0] REQ_ICONS       = 4'd4;
  localparam logic [3:0] REQ_ICON_EDIT   = 4'd5;
  localparam logic [3:0] REQ_BLINK_START = 4'd6;
  localparam logic [3:0] REQ_BLINK_STOP  = 4'd7;
  localparam logic [3:0] REQ_TICK        = 4'd8;

  typedef enum logic [2:0] {
    OP_LOAD_DIGITS,
    OP_CLEAR,
    OP_COLON,
    OP_ICONS,
    OP_ICON_EDIT,
    OP_BLINK_START,
    OP_BLINK_STOP,
    OP_TICK
  } op_t;

  typedef logic [3:0] digit_t;
  typedef digit_t [DIGIT_SLOTS-1:0] digits_t;

  // One classified command. Time and number requests both arrive as a
  // digit load; the colon update for a time request rides in set_colon.
  typedef struct packed {
    op_t         op;
    digits_t     digits;
    logic        set_colon;
    logic        flag;
    logic [7:0]  icons;
    logic [12:0] sel;
    logic [15:0] period;
  } cmd_t;

endpackage

FILE: sv/fdfb_if.sv
// Channel interfaces of the display frame blinker: request items in and
// frame items out, each with valid/ready. Depends on nothing.
interface fdfb_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [4:0]  hours_in;
  logic [5:0]  minutes_in;
  logic [15:0] value_in;
  logic        pad_zeros;
  logic        enable_flag;
  logic [7:0]  icon_bits;
  logic [12:0] blink_select;
  logic [15:0] period_ticks;

  modport source (output valid, req_type, hours_in, minutes_in, value_in, pad_zeros,
                  enable_flag, icon_bits, blink_select, period_ticks, input ready);
  modport sink (input valid, req_type, hours_in, minutes_in, value_in, pad_zeros,
                enable_flag, icon_bits, blink_select, period_ticks, output ready);
  modport monitor (input valid, ready, req_type, hours_in, minutes_in, value_in,
                   pad_zeros, enable_flag, icon_bits, blink_select, period_ticks);
endinterface

interface fdfb_frame_if;
  logic       valid;
  logic       ready;
  logic [3:0] shown_d0;
  logic [3:0] shown_d1;
  logic [3:0] shown_d2;
  logic [3:0] shown_d3;
  logic       colon_lit;
  logic [7:0] icons_lit;

  modport source (output valid, shown_d0, shown_d1, shown_d2, shown_d3, colon_lit,
                  icons_lit, input ready);
  modport sink (input valid, shown_d0, shown_d1, shown_d2, shown_d3, colon_lit,
                icons_lit, output ready);
  modport monitor (input valid, ready, shown_d0, shown_d1, shown_d2, shown_d3,
                   colon_lit, icons_lit);
endinterface

FILE: sv/four_digit_display_frame_blinker.sv
// Top level of the four-digit display frame blinker. Instantiates the front
// end, the command queue and the back end; depends on fdfb_pkg and fdfb_if.
//
// Use: requests arrive on the req channel (valid/ready). Each item carries
// a request code and all operand fields; only those the code needs are used.
// Unknown codes are accepted and dropped. Frame items leave on the frame
// channel (valid/ready): four digit codes, the colon and the icon bits, with
// blinking parts hidden while the blink phase is invisible.
// Every frame-changing request and every phase toggle gives one frame item;
// ticks that only count down, and ticks while nothing blinks, give none.
// Throughput: one request per cycle while the queue is not full. The front end
// classifies the request and converts numbers to decimal in the cycle it is
// accepted, writing the result into a four-entry queue; the back end applies
// one command per cycle from that queue to the frame registers unless stalled.
// Path: each accepted request passes through the queue and then the output
// register before its frame item is valid on the frame channel.
// Stall: if the frame receiver holds ready low, the output register keeps
// its item, the back end stops, and the queue absorbs up to four requests
// before req.ready falls. Reset (rst, synchronous) empties the queue, drops
// any pending frame item and returns the frame to all blanks, no blinking.
module four_digit_display_frame_blinker #(
  parameter int ICON_SLOTS   = fdfb_pkg::ICON_SLOTS_DEF,
  parameter int PERIOD_WIDTH = fdfb_pkg::PERIOD_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  fdfb_req_if.sink      req,
  fdfb_frame_if.source  frame
);
  import fdfb_pkg::*;

  // Front end to queue.
  logic push;
  logic full;
  cmd_t push_cmd;

  // Queue to back end.
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  fdfb_front u_front (
    .req  (req),
    .full (full),
    .push (push),
    .cmd  (push_cmd)
  );

  fdfb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .valid    (head_valid),
    .head     (head_cmd)
  );

  // The back end owns all display state; it pops only when its output
  // register is empty or being emptied in the same cycle.
  fdfb_back #(
    .ICON_SLOTS   (ICON_SLOTS),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .pop       (pop),
    .frame     (frame)
  );

endmodule

FILE: sv/fdfb_queue.sv
// Short command queue between front and back end of the frame blinker.
// Depends on fdfb_pkg for the command type and the queue depth.
module fdfb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fdfb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output fdfb_pkg::cmd_t head
);
  import fdfb_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/fdfb_front.sv
// Front end of the frame blinker: accepts request items, drops unknown codes
// and turns time and number requests into digit codes. Depends on fdfb_pkg.
module fdfb_front (
  fdfb_req_if.sink       req,
  input  logic           full,
  output logic           push,
  output fdfb_pkg::cmd_t cmd
);
  import fdfb_pkg::*;

  // Divisions by constants through reciprocal multiplication; exact for
  // every argument below 16384.
  function automatic logic [10:0] div10(input logic [13:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd6554;
    return p[26:16];
  endfunction

  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd5243;
    return p[26:19];
  endfunction

  function automatic logic [4:0] div1000(input logic [13:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd8389;
    return p[27:23];
  endfunction

  function automatic logic [13:0] mul10(input logic [13:0] x);
    return (x << 3) + (x << 1);
  endfunction

  logic        known;
  logic [10:0] hrs_tens;
  logic [10:0] min_tens;
  logic [13:0] num;
  logic [4:0]  q1000;
  logic [7:0]  q100;
  logic [10:0] q10;
  digits_t     time_digits;
  digits_t     num_digits;

  assign req.ready = !full;
  assign push      = req.valid && !full && known;

  always_comb begin
    hrs_tens = div10(14'(req.hours_in));
    min_tens = div10(14'(req.minutes_in));
    time_digits[0] = hrs_tens[3:0];
    time_digits[1] = 4'(14'(req.hours_in) - mul10(14'(hrs_tens)));
    time_digits[2] = min_tens[3:0];
    time_digits[3] = 4'(14'(req.minutes_in) - mul10(14'(min_tens)));
  end

  // Leading digits are blank while the remaining quotient is zero, unless padded.
  always_comb begin
    num   = (req.value_in > NUM_MAX) ? NUM_MAX[13:0] : req.value_in[13:0];
    q1000 = div1000(num);
    q100  = div100(num);
    q10   = div10(num);
    num_digits[0] = (req.pad_zeros || q1000 != '0) ? q1000[3:0] : BLANK_CODE;
    num_digits[1] = (req.pad_zeros || q100 != '0)
                    ? 4'(14'(q100) - mul10(14'(q1000))) : BLANK_CODE;
    num_digits[2] = (req.pad_zeros || q10 != '0)
                    ? 4'(14'(q10) - mul10(14'(q100))) : BLANK_CODE;
    num_digits[3] = 4'(num - mul10(14'(q10)));
  end

  always_comb begin
    known         = 1'b1;
    cmd.op        = OP_TICK;
    cmd.digits    = time_digits;
    cmd.set_colon = 1'b0;
    cmd.flag      = req.enable_flag;
    cmd.icons     = req.icon_bits;
    cmd.sel       = req.blink_select;
    cmd.period    = req.period_ticks;
    case (req.req_type)
      REQ_CLEAR:       cmd.op = OP_CLEAR;
      REQ_TIME: begin
        cmd.op        = OP_LOAD_DIGITS;
        cmd.set_colon = 1'b1;
      end
      REQ_NUMBER: begin
        cmd.op     = OP_LOAD_DIGITS;
        cmd.digits = num_digits;
      end
      REQ_COLON:       cmd.op = OP_COLON;
      REQ_ICONS:       cmd.op = OP_ICONS;
      REQ_ICON_EDIT:   cmd.op = OP_ICON_EDIT;
      REQ_BLINK_START: cmd.op = OP_BLINK_START;
      REQ_BLINK_STOP:  cmd.op = OP_BLINK_STOP;
      REQ_TICK:        cmd.op = OP_TICK;
      default:         known  = 1'b0;
    endcase
  end

endmodule

FILE: sv/fdfb_back.sv
// Back end of the frame blinker: holds the frame and blink state, applies
// commands and registers the masked frame. Depends on fdfb_pkg.
module fdfb_back #(
  parameter int ICON_SLOTS   = fdfb_pkg::ICON_SLOTS_DEF,
  parameter int PERIOD_WIDTH = fdfb_pkg::PERIOD_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  fdfb_pkg::cmd_t cmd,
  output logic           pop,
  fdfb_frame_if.source   frame
);
  import fdfb_pkg::*;

  digits_t                 digits, digits_next;
  logic                    colon, colon_next;
  logic [ICON_SLOTS-1:0]   icons, icons_next;
  logic [12:0]             sel, sel_next;
  logic [PERIOD_WIDTH-1:0] period, period_next;
  logic [PERIOD_WIDTH-1:0] countdown, countdown_next;
  logic                    phase, phase_next;
  logic                    emit;

  logic                    out_valid;
  digits_t                 out_digits;
  logic                    out_colon;
  logic [7:0]              out_icons;

  logic [PERIOD_WIDTH-1:0] period_in;
  logic [ICON_SLOTS-1:0]   icons_in;
  logic                    hide;
  digits_t                 show_digits;
  logic                    show_colon;
  logic [ICON_SLOTS-1:0]   show_icons;

  assign pop = cmd_valid && (!out_valid || frame.ready);

  assign period_in = PERIOD_WIDTH'(cmd.period);
  assign icons_in  = cmd.icons[ICON_SLOTS-1:0];

  always_comb begin
    digits_next    = digits;
    colon_next     = colon;
    icons_next     = icons;
    sel_next       = sel;
    period_next    = period;
    countdown_next = countdown;
    phase_next     = phase;
    emit           = 1'b1;
    case (cmd.op)
      OP_CLEAR: begin
        digits_next = {DIGIT_SLOTS{BLANK_CODE}};
        colon_next  = 1'b0;
        icons_next  = '0;
      end
      OP_LOAD_DIGITS: begin
        digits_next = cmd.digits;
        if (cmd.set_colon) begin
          colon_next = cmd.flag;
        end
      end
      OP_COLON:     colon_next = cmd.flag;
      OP_ICONS:     icons_next = icons_in;
      OP_ICON_EDIT: icons_next = cmd.flag ? (icons | icons_in) : (icons & ~icons_in);
      OP_BLINK_START: begin
        sel_next       = cmd.sel;
        period_next    = (period_in == '0) ? PERIOD_WIDTH'(1) : period_in;
        countdown_next = period_next;
        phase_next     = 1'b1;
      end
      OP_BLINK_STOP: begin
        sel_next   = '0;
        phase_next = 1'b1;
      end
      OP_TICK: begin
        if (sel == '0) begin
          emit = 1'b0;
        end else if (countdown <= PERIOD_WIDTH'(1)) begin
          phase_next     = !phase;
          countdown_next = period;
        end else begin
          countdown_next = countdown - 1'b1;
          emit           = 1'b0;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // Masking is applied to the state as it stands after the command.
  always_comb begin
    hide = (sel_next != '0) && !phase_next;
    for (int k = 0; k < DIGIT_SLOTS; k++) begin
      show_digits[k] = (hide && sel_next[k]) ? BLANK_CODE : digits_next[k];
    end
    show_colon = colon_next && !(hide && sel_next[COLON_BIT]);
    show_icons = icons_next & ~(hide ? sel_next[ICON_SHIFT +: ICON_SLOTS] : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits    <= {DIGIT_SLOTS{BLANK_CODE}};
      colon     <= 1'b0;
      icons     <= '0;
      sel       <= '0;
      period    <= PERIOD_WIDTH'(1);
      countdown <= '0;
      phase     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        digits    <= digits_next;
        colon     <= colon_next;
        icons     <= icons_next;
        sel       <= sel_next;
        period    <= period_next;
        countdown <= countdown_next;
        phase     <= phase_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (frame.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_digits <= show_digits;
      out_colon  <= show_colon;
      out_icons  <= 8'(show_icons);
    end
  end

  assign frame.valid     = out_valid;
  assign frame.shown_d0  = out_digits[0];
  assign frame.shown_d1  = out_digits[1];
  assign frame.shown_d2  = out_digits[2];
  assign frame.shown_d3  = out_digits[3];
  assign frame.colon_lit = out_colon;
  assign frame.icons_lit = out_icons;

endmodule

FILE: sv/fdfb_checker.sv
// Port-level checker for the display frame blinker, bound to the top level.
// Depends on fdfb_pkg, fdfb_if and assert_macros.svh.
`include "assert_macros.svh"

module fdfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       frame_valid,
  input logic       frame_ready,
  input logic [3:0] shown_d0,
  input logic [3:0] shown_d1,
  input logic [3:0] shown_d2,
  input logic [3:0] shown_d3,
  input logic       colon_lit,
  input logic [7:0] icons_lit
);
  import fdfb_pkg::*;

  // A digit code is either a decimal digit or the blank code.
  function automatic logic code_ok(input logic [3:0] d);
    return (d <= 4'd9) || (d == BLANK_CODE);
  endfunction

  logic [24:0] frame_bits;
  logic        digits_ok;

  assign frame_bits = {shown_d0, shown_d1, shown_d2, shown_d3, colon_lit, icons_lit};
  assign digits_ok  = code_ok(shown_d0) && code_ok(shown_d1) && code_ok(shown_d2) &&
                      code_ok(shown_d3);

  `FDFB_ASSERT_NXT(a_frame_hold, clk, rst, frame_valid && !frame_ready, frame_valid && $stable(frame_bits))
  `FDFB_ASSERT_NXT(a_reset_no_frame, clk, 1'b0, rst, !frame_valid)
  `FDFB_ASSERT_NXT(a_reset_ready, clk, 1'b0, rst, req_ready)
  `FDFB_ASSERT_IMP(a_digit_codes, clk, rst, frame_valid, digits_ok)

endmodule

bind four_digit_display_frame_blinker fdfb_checker u_fdfb_checker (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (req.ready),
  .frame_valid (frame.valid),
  .frame_ready (frame.ready),
  .shown_d0    (frame.shown_d0),
  .shown_d1    (frame.shown_d1),
  .shown_d2    (frame.shown_d2),
  .shown_d3    (frame.shown_d3),
  .colon_lit   (frame.colon_lit),
  .icons_lit   (frame.icons_lit)
);

FILE: verif/tb_four_digit_display_frame_blinker.sv
`timescale 1ns / 100ps
// Self-checking testbench for the four-digit display frame blinker: a table of
// directed requests then weighted random traffic, scored against a frame
// predictor or typed frame. Depends on fdfb_pkg, fdfb_if and the RTL top level.
module tb_four_digit_display_frame_blinker;
  import fdfb_pkg::*;

  // One request item as it travels on the request channel.
  typedef struct packed {
    logic [3:0]  code;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [15:0] value;
    logic        pad;
    logic        flag;
    logic [7:0]  icons;
    logic [12:0] sel;
    logic [15:0] period;
  } request_t;

  // One frame item; digits[0] is the leftmost digit (shown_d0).
  typedef struct packed {
    digits_t    digits;
    logic       colon;
    logic [7:0] icons;
  } frame_t;

  // A directed row: the request, and optionally a frame typed in by hand.
  typedef struct packed {
    request_t rq;
    logic     pinned;
    frame_t   want;
  } stim_row_t;

  localparam int RANDOM_ITEMS = 950;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE_TICKS = 10;

  logic clk;
  logic rst;

  fdfb_req_if   req_ch ();
  fdfb_frame_if frame_ch ();

  four_digit_display_frame_blinker DUT (
    .clk   (clk),
    .rst   (rst),
    .req   (req_ch),
    .frame (frame_ch)
  );

  // The clock runs freely at 100 MHz.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Frame predictor. It keeps its own copy of the display frame and of the
  // blink machinery, and works out the frame item (if any) that one accepted
  // request produces.
  // ---------------------------------------------------------------------------
  digit_t      digit_reg [DIGIT_SLOTS];
  logic        colon_reg;
  logic [7:0]  icon_reg;
  logic [12:0] blink_targets;
  logic [15:0] half_period;
  logic [15:0] tick_count;
  logic        phase_shown;

  frame_t frame_queue [$];
  int     error_count;

  task automatic reset_frame_model();
    for (int k = 0; k < DIGIT_SLOTS; k++) digit_reg[k] = BLANK_CODE;
    colon_reg     = 1'b0;
    icon_reg      = 8'h00;
    blink_targets = 13'h0000;
    half_period   = 16'd1;
    tick_count    = 16'd0;
    phase_shown   = 1'b1;
  endtask

  task automatic predict_frame(input request_t r, output bit emits, output frame_t f);
    int unsigned n;
    bit          show;
    emits = 1'b1;
    case (r.code)
      REQ_CLEAR: begin
        for (int k = 0; k < DIGIT_SLOTS; k++) digit_reg[k] = BLANK_CODE;
        colon_reg = 1'b0;
        icon_reg  = 8'h00;
      end
      REQ_TIME: begin
        // Out-of-range hours and minutes are still split into tens and units.
        digit_reg[0] = digit_t'(r.hours / 10);
        digit_reg[1] = digit_t'(r.hours % 10);
        digit_reg[2] = digit_t'(r.minutes / 10);
        digit_reg[3] = digit_t'(r.minutes % 10);
        colon_reg    = r.flag;
      end
      REQ_NUMBER: begin
        // Saturate, then peel decimal digits from the right. Leading zeros
        // are blanked unless padding is asked, but the rightmost digit always
        // shows, so zero appears as a single 0.
        n = (r.value > NUM_MAX) ? 32'(NUM_MAX) : 32'(r.value);
        for (int k = DIGIT_SLOTS - 1; k >= 0; k--) begin
          show = r.pad || (n > 0) || (k == DIGIT_SLOTS - 1);
          digit_reg[k] = show ? digit_t'(n % 10) : BLANK_CODE;
          n = n / 10;
        end
      end
      REQ_COLON:     colon_reg = r.flag;
      REQ_ICONS:     icon_reg  = r.icons;
      REQ_ICON_EDIT: icon_reg  = r.flag ? (icon_reg | r.icons) : (icon_reg & ~r.icons);
      REQ_BLINK_START: begin
        // A zero mask is kept as it is and simply means nothing blinks.
        blink_targets = r.sel;
        half_period   = (r.period == 16'd0) ? 16'd1 : r.period;
        phase_shown   = 1'b1;
        tick_count    = half_period;
      end
      REQ_BLINK_STOP: begin
        blink_targets = 13'h0000;
        phase_shown   = 1'b1;
      end
      REQ_TICK: begin
        // Ticks do nothing while nothing blinks; otherwise they count down and
        // only the tick that finds the count at one or zero toggles the phase.
        if (blink_targets == 13'h0000) begin
          emits = 1'b0;
        end else if (tick_count <= 16'd1) begin
          phase_shown = ~phase_shown;
          tick_count  = half_period;
        end else begin
          tick_count = tick_count - 16'd1;
          emits      = 1'b0;
        end
      end
      default: emits = 1'b0;
    endcase

    // Build the visible frame, hiding the blinking parts in the dark phase.
    for (int k = 0; k < DIGIT_SLOTS; k++) f.digits[k] = digit_reg[k];
    f.colon = colon_reg;
    f.icons = icon_reg;
    if (blink_targets != 13'h0000 && !phase_shown) begin
      for (int k = 0; k < DIGIT_SLOTS; k++)
        if (blink_targets[k]) f.digits[k] = BLANK_CODE;
      if (blink_targets[COLON_BIT]) f.colon = 1'b0;
      f.icons = f.icons & ~blink_targets[ICON_SHIFT +: 8];
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Both channels are sampled at the rising edge, before any of the
  // edge's nonblocking updates land, so each handshake is seen exactly as the
  // design saw it. A frame item is checked before the request of the same edge
  // is predicted; a request crosses the queue and output register first, so the
  // two are never related. row_pinned and row_want ride with the request fields
  // and carry a hand-typed frame for some of the directed rows.
  // ---------------------------------------------------------------------------
  logic   row_pinned;
  frame_t row_want;

  always @(posedge clk) begin
    frame_t   got;
    frame_t   want;
    frame_t   model_frame;
    request_t seen;
    bit       emits;
    if (!rst) begin
      if (frame_ch.valid && frame_ch.ready) begin
        got.digits[0] = frame_ch.shown_d0;
        got.digits[1] = frame_ch.shown_d1;
        got.digits[2] = frame_ch.shown_d2;
        got.digits[3] = frame_ch.shown_d3;
        got.colon     = frame_ch.colon_lit;
        got.icons     = frame_ch.icons_lit;
        if (frame_queue.size() == 0) begin
          $error("frame item with nothing expected: %h", got);
          error_count++;
        end else begin
          want = frame_queue.pop_front();
          for (int k = 0; k < DIGIT_SLOTS; k++) begin
            if (got.digits[k] !== want.digits[k]) begin
              $error("shown_d%0d: expected %0d, actual %0d", k, want.digits[k], got.digits[k]);
              error_count++;
            end
          end
          if (got.colon !== want.colon) begin
            $error("colon_lit: expected %0d, actual %0d", want.colon, got.colon);
            error_count++;
          end
          if (got.icons !== want.icons) begin
            $error("icons_lit: expected %h, actual %h", want.icons, got.icons);
            error_count++;
          end
        end
      end

      if (req_ch.valid && req_ch.ready) begin
        seen.code    = req_ch.req_type;
        seen.hours   = req_ch.hours_in;
        seen.minutes = req_ch.minutes_in;
        seen.value   = req_ch.value_in;
        seen.pad     = req_ch.pad_zeros;
        seen.flag    = req_ch.enable_flag;
        seen.icons   = req_ch.icon_bits;
        seen.sel     = req_ch.blink_select;
        seen.period  = req_ch.period_ticks;
        predict_frame(seen, emits, model_frame);
        // A hand-typed frame takes the place of the predicted one.
        if (row_pinned) frame_queue.push_back(row_want);
        else if (emits) frame_queue.push_back(model_frame);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame receiver. When stall_cycle % 50 reaches 49 it picks a new stall pattern:
  // always ready, coin-flip ready, ready while stall_cycle % 4 is 0, or while
  // stall_cycle % 8 is 0. The first gives long stretches with no back-pressure.
  // ---------------------------------------------------------------------------
  int unsigned stall_cycle;
  int unsigned stall_mode;

  always @(posedge clk) begin
    if (rst) begin
      stall_cycle <= 0;
      stall_mode  <= 0;
      frame_ch.ready <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 50 == 49) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       frame_ch.ready <= 1'b1;
        1:       frame_ch.ready <= 1'($urandom_range(0, 1));
        2:       frame_ch.ready <= (stall_cycle % 4 == 0);
        default: frame_ch.ready <= (stall_cycle % 8 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request sender. Items go out in bursts of random length; between bursts
  // valid drops for a random number of cycles. The task is entered at a rising
  // edge and returns at the edge where the item was taken, or after the gap
  // that ends a burst; back-to-back items keep valid high in between.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;

  task automatic send_request(input request_t r, input logic pinned, input frame_t want);
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.code;
    req_ch.hours_in     <= r.hours;
    req_ch.minutes_in   <= r.minutes;
    req_ch.value_in     <= r.value;
    req_ch.pad_zeros    <= r.pad;
    req_ch.enable_flag  <= r.flag;
    req_ch.icon_bits    <= r.icons;
    req_ch.blink_select <= r.sel;
    req_ch.period_ticks <= r.period;
    row_pinned          <= pinned;
    row_want            <= want;
    do @(posedge clk); while (!req_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // Now and then a long burst, so that whole stretches run with no gaps.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    end
  endtask

  // Random request, weighted towards ticks and blink control so that blinking
  // sessions with many phase toggles make up most of the traffic.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r.hours   = 5'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 23)
                                                : $urandom_range(24, 31));
    r.minutes = 6'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 59)
                                                : $urandom_range(60, 63));
    pick = $urandom_range(0, 2);
    r.value   = 16'((pick == 0) ? $urandom_range(0, 99) :
                    (pick == 1) ? $urandom_range(0, 9999) : $urandom_range(0, 65535));
    r.pad     = 1'($urandom_range(0, 1));
    r.flag    = 1'($urandom_range(0, 1));
    r.icons   = 8'($urandom_range(0, 255));
    r.sel     = ($urandom_range(0, 99) < 15) ? 13'h0000 : 13'($urandom_range(0, 8191));
    pick = $urandom_range(0, 9);
    r.period  = 16'((pick < 7) ? $urandom_range(0, 4) :
                    (pick < 9) ? $urandom_range(5, 20) : $urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if      (pick < 35) r.code = REQ_TICK;
    else if (pick < 43) r.code = REQ_BLINK_START;
    else if (pick < 47) r.code = REQ_BLINK_STOP;
    else if (pick < 59) r.code = REQ_NUMBER;
    else if (pick < 69) r.code = REQ_TIME;
    else if (pick < 74) r.code = REQ_COLON;
    else if (pick < 79) r.code = REQ_ICONS;
    else if (pick < 89) r.code = REQ_ICON_EDIT;
    else if (pick < 92) r.code = REQ_CLEAR;
    else if (pick < 97) r.code = 4'($urandom_range(9, 15));
    else                r.code = 4'($urandom_range(0, 15));
    return r;
  endfunction

  function automatic request_t make_request(input logic [3:0] code, input int unsigned hours,
                                            input int unsigned minutes, input int unsigned value,
                                            input logic pad, input logic flag,
                                            input int unsigned icons, input int unsigned sel,
                                            input int unsigned period);
    request_t r;
    r.code    = code;
    r.hours   = 5'(hours);
    r.minutes = 6'(minutes);
    r.value   = 16'(value);
    r.pad     = pad;
    r.flag    = flag;
    r.icons   = 8'(icons);
    r.sel     = 13'(sel);
    r.period  = 16'(period);
    return r;
  endfunction

  function automatic frame_t make_frame(input digit_t d0, input digit_t d1, input digit_t d2,
                                        input digit_t d3, input logic colon,
                                        input logic [7:0] icons);
    frame_t f;
    f.digits[0] = d0;
    f.digits[1] = d1;
    f.digits[2] = d2;
    f.digits[3] = d3;
    f.colon     = colon;
    f.icons     = icons;
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with a typed frame are those whose result is obvious
  // from the frame after reset or from an extreme value; the rest are left to
  // the predictor. The order matters: the frame builds up from reset, then a
  // blink session runs through a zero period, a zero mask and a longer period.
  // ---------------------------------------------------------------------------
  stim_row_t stim_rows [$];
  frame_t    no_frame;

  task automatic add_row(input request_t r, input logic pinned, input frame_t want);
    stim_row_t row;
    row.rq     = r;
    row.pinned = pinned;
    row.want   = want;
    stim_rows.push_back(row);
  endtask

  task automatic build_table();
    no_frame = '0;
    // A tick with nothing blinking, and unused codes, give nothing.
    add_row(make_request(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_frame);
    add_row(make_request(4'd9, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_frame);
    add_row(make_request(4'd15, 31, 63, 65535, 1, 1, 255, 8191, 65535), 1'b0, no_frame);
    // Number extremes: zero without and with padding, and saturation.
    add_row(make_request(REQ_NUMBER, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            make_frame(BLANK_CODE, BLANK_CODE, BLANK_CODE, 4'd0, 1'b0, 8'h00));
    add_row(make_request(REQ_NUMBER, 0, 0, 65535, 0, 0, 0, 0, 0), 1'b1,
            make_frame(4'd9, 4'd9, 4'd9, 4'd9, 1'b0, 8'h00));
    add_row(make_request(REQ_NUMBER, 0, 0, 0, 1, 0, 0, 0, 0), 1'b1,
            make_frame(4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 8'h00));
    add_row(make_request(REQ_NUMBER, 0, 0, 42, 0, 0, 0, 0, 0), 1'b0, no_frame);
    add_row(make_request(REQ_NUMBER, 0, 0, 1000, 0, 0, 0, 0, 0), 1'b0, no_frame);
    // Time: the top legal value, out-of-range hours and minutes, and midnight.
    add_row(make_request(REQ_TIME, 23, 59, 0, 0, 1, 0, 0, 0), 1'b1,
            make_frame(4'd2, 4'd3, 4'd5, 4'd9, 1'b1, 8'h00));
    add_row(make_request(REQ_TIME, 31, 63, 0, 0, 0, 0, 0, 0), 1'b1,
            make_frame(4'd3, 4'd1, 4'd6, 4'd3, 1'b0, 8'h00));
    add_row(make_request(REQ_TIME, 0, 0, 0, 0, 1, 0, 0, 0), 1'b1,
            make_frame(4'd0, 4'd0, 4'd0, 4'd0, 1'b1, 8'h00));
    add_row(make_request(REQ_COLON, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_frame);
    add_row(make_request(REQ_ICONS, 0, 0, 0, 0, 0, 255, 0, 0), 1'b0, no_frame);
    add_row(make_request(REQ_ICON_EDIT, 0, 0, 0, 0, 0, 8'h0F, 0, 0), 1'b0, no_frame);
    add_row(make_request(REQ_ICON_EDIT, 0, 0, 0, 0, 1, 8'h01, 0, 0), 1'b0, no_frame);
    // Blink everything with a zero period, which behaves as one tick.
    add_row(make_request(REQ_BLINK_START, 0, 0, 0, 0, 0, 0, 8191, 0), 1'b0, no_frame);
    add_row(make_request(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_frame);
    add_row(make_request(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_frame);
    // A zero blink mask means no blinking, so the tick gives nothing.
    add_row(make_request(REQ_BLINK_START, 0, 0, 0, 0, 0, 0, 0, 3), 1'b0, no_frame);
    add_row(make_request(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_frame);
    // A two-tick half period: the first tick only counts down.
    add_row(make_request(REQ_BLINK_START, 0, 0, 0, 0, 0, 0, 13'h0015, 2), 1'b0, no_frame);
    add_row(make_request(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_frame);
    add_row(make_request(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_frame);
    add_row(make_request(REQ_BLINK_STOP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_frame);
    add_row(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            make_frame(BLANK_CODE, BLANK_CODE, BLANK_CODE, BLANK_CODE, 1'b0, 8'h00));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random traffic, then drain.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned waited;
    // Every input starts at a known value before the first edge.
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_CLEAR;
    req_ch.hours_in     = '0;
    req_ch.minutes_in   = '0;
    req_ch.value_in     = '0;
    req_ch.pad_zeros    = 1'b0;
    req_ch.enable_flag  = 1'b0;
    req_ch.icon_bits    = '0;
    req_ch.blink_select = '0;
    req_ch.period_ticks = '0;
    frame_ch.ready      = 1'b0;
    row_pinned          = 1'b0;
    row_want            = '0;
    error_count         = 0;
    burst_left          = 0;
    reset_frame_model();
    build_table();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) send_request(stim_rows[i].rq, stim_rows[i].pinned, stim_rows[i].want);
    repeat (RANDOM_ITEMS) send_request(random_request(), 1'b0, no_frame);
    req_ch.valid <= 1'b0;

    // Wait for the last frames, then a little longer to catch any extra one.
    waited = 0;
    while (frame_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      $display("four_digit_display_frame_blinker test failed");
      $finish;
    end else begin
      repeat (SETTLE_TICKS) @(posedge clk);
      if (error_count == 0 && frame_queue.size() == 0) begin
        $display("four_digit_display_frame_blinker test passed");
      end else begin
        $display("four_digit_display_frame_blinker test failed");
      end
      $finish;
    end
  end

  // Watchdog: reports a failure and stops if the run never finishes.
  initial begin
    #2_000_000;
    $display("four_digit_display_frame_blinker test failed");
    $finish;
  end

endmodule
